@@ rtl/core/scg_pkg.sv @@
`timescale 1ns / 1ps

package scg_pkg;

    localparam int ANGLE_W         = 16;
    localparam int CH_W            = 8;
    localparam int N_CH            = 4;
    localparam int COLOR_W         = CH_W * N_CH;
    localparam int ANGLE_FRAC_BITS = 4;

    // angles in 1/2^ANGLE_FRAC_BITS degree
    localparam int FULL_TURN = 360 << ANGLE_FRAC_BITS;
    localparam int SEG_LEN   = 30 << ANGLE_FRAC_BITS;
    localparam int DAY_LO    = 30 << ANGLE_FRAC_BITS;
    localparam int DAY_HI    = 150 << ANGLE_FRAC_BITS;
    localparam int DUSK_MID  = 180 << ANGLE_FRAC_BITS;
    localparam int NIGHT_LO  = 210 << ANGLE_FRAC_BITS;
    localparam int NIGHT_HI  = 330 << ANGLE_FRAC_BITS;

    // angle + 32768 + WRAP_OFS is a non-negative value congruent to angle
    localparam int WRAP_K   = (32768 + FULL_TURN - 1) / FULL_TURN;
    localparam int WRAP_OFS = WRAP_K * FULL_TURN - 32768;
    localparam int U_MAX    = 65535 + WRAP_OFS;
    localparam int U_W      = $clog2(U_MAX + 1);
    localparam int Q_W      = $clog2(U_MAX / FULL_TURN + 1);
    localparam int M_W      = $clog2(FULL_TURN);
    localparam int OFF_W    = $clog2(SEG_LEN);

    // floor(u / FULL_TURN) = (u * Q_RECIP) >> Q_SH for all u <= U_MAX
    localparam int    Q_SH    = $clog2(64'(U_MAX + 1) * 64'(FULL_TURN));
    localparam longint Q_RECIP = (64'd1 << Q_SH) / FULL_TURN + 1;
    localparam int    R_W     = $clog2(Q_RECIP + 1);

    // blend numerator and rounding divide by SEG_LEN
    localparam int    X_MAX   = 255 * SEG_LEN + SEG_LEN / 2;
    localparam int    NUM_W   = $clog2(X_MAX + 1);
    localparam int    SUM_W   = CH_W + OFF_W + 3;
    localparam int    D_SH    = $clog2(64'(X_MAX + 1) * 64'(SEG_LEN));
    localparam longint D_RECIP = (64'd1 << D_SH) / SEG_LEN + 1;
    localparam int    DR_W    = $clog2(D_RECIP + 1);

    // register map
    localparam int         ADDR_W    = 4;
    localparam int         DATA_W    = 32;
    localparam logic [1:0] REG_DAY   = 2'd0;
    localparam logic [1:0] REG_NIGHT = 2'd1;
    localparam logic [1:0] REG_DAWN  = 2'd2;

    localparam logic [COLOR_W-1:0] DAY_RST   = 32'h87CE_EBFF;
    localparam logic [COLOR_W-1:0] NIGHT_RST = 32'h1919_70FF;
    localparam logic [COLOR_W-1:0] DAWN_RST  = 32'hFA80_72FF;

    typedef struct packed {
        logic [COLOR_W-1:0] s_color;
        logic [COLOR_W-1:0] e_color;
        logic [OFF_W-1:0]   off;
    } t_sel_beat;

endpackage

@@ rtl/core/scg_angle_if.sv @@
`timescale 1ns / 1ps

interface scg_angle_if;
    logic                        valid;
    logic                        ready;
    logic [scg_pkg::ANGLE_W-1:0] angle;

    modport source (output valid, output angle, input ready);
    modport sink   (input valid, input angle, output ready);
endinterface

@@ rtl/core/scg_color_if.sv @@
`timescale 1ns / 1ps

interface scg_color_if;
    logic                     valid;
    logic                     ready;
    logic [scg_pkg::CH_W-1:0] red;
    logic [scg_pkg::CH_W-1:0] green;
    logic [scg_pkg::CH_W-1:0] blue;
    logic [scg_pkg::CH_W-1:0] alpha;

    modport source (output valid, output red, output green, output blue, output alpha,
                    input ready);
    modport sink   (input valid, input red, input green, input blue, input alpha,
                    output ready);
endinterface

@@ rtl/core/sky_color_gradient.sv @@
`timescale 1ns / 1ps

// channel   dir   kind   payload
// i_angle   in    v/r    angle, signed 16 bits, 1/16 degree
// o_color   out   v/r    red, green, blue, alpha, 8 bits each
// apb       in    apb    day_color @0x0, night_color @0x4, dawn_color @0x8
//
// six register stages: bias, reciprocal multiply, wrap subtract, segment select,
// blend multiply, rounding divide; a beat may enter every cycle while the
// pipeline is not held. one beat out per beat in.
// reset is synchronous: pipeline valid bits clear, colors take their defaults.
// the whole pipeline holds while a finished beat waits on o_color.ready.

module sky_color_gradient (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    scg_angle_if.sink                   i_angle,
    scg_color_if.source                 o_color,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [scg_pkg::ADDR_W-1:0]  paddr,
    input  logic [scg_pkg::DATA_W-1:0]  pwdata,
    output logic [scg_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);

    logic [scg_pkg::COLOR_W-1:0] r_day, r_night, r_dawn;

    logic                    w_en;
    logic                    w_wrap_v;
    logic [scg_pkg::M_W-1:0] w_m;
    logic                    w_sel_v;
    scg_pkg::t_sel_beat      w_sel;
    logic                    w_wr;
    logic [1:0]              w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;
    assign w_idx  = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_day   <= scg_pkg::DAY_RST;
            r_night <= scg_pkg::NIGHT_RST;
            r_dawn  <= scg_pkg::DAWN_RST;
        end else if (w_wr) begin
            case (w_idx)
                scg_pkg::REG_DAY:   r_day   <= pwdata;
                scg_pkg::REG_NIGHT: r_night <= pwdata;
                scg_pkg::REG_DAWN:  r_dawn  <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            scg_pkg::REG_DAY:   prdata = r_day;
            scg_pkg::REG_NIGHT: prdata = r_night;
            scg_pkg::REG_DAWN:  prdata = r_dawn;
            default:            prdata = '0;
        endcase
    end

    assign w_en          = !o_color.valid || o_color.ready;
    assign i_angle.ready = w_en;

    scg_wrap u_wrap (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_angle.valid),
        .i_angle (i_angle.angle),
        .o_valid (w_wrap_v),
        .o_m     (w_m)
    );

    scg_select u_select (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_wrap_v),
        .i_m     (w_m),
        .i_day   (r_day),
        .i_night (r_night),
        .i_dawn  (r_dawn),
        .o_valid (w_sel_v),
        .o_beat  (w_sel)
    );

    scg_blend u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_sel_v),
        .i_beat  (w_sel),
        .o_valid (o_color.valid),
        .o_red   (o_color.red),
        .o_green (o_color.green),
        .o_blue  (o_color.blue),
        .o_alpha (o_color.alpha)
    );

    a_wrap_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wrap_v |-> (w_m < scg_pkg::M_W'(scg_pkg::FULL_TURN)))
        else $error("wrapped angle out of range");

    a_off_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sel_v |-> (w_sel.off < scg_pkg::OFF_W'(scg_pkg::SEG_LEN)))
        else $error("segment offset out of range");

    a_sel_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_sel_v && !w_en) |=> (w_sel_v && $stable(w_sel)))
        else $error("select stage changed during stall");

endmodule

@@ rtl/core/scg_wrap.sv @@
`timescale 1ns / 1ps

module scg_wrap (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [scg_pkg::ANGLE_W-1:0] i_angle,
    output logic                        o_valid,
    output logic [scg_pkg::M_W-1:0]     o_m
);

    logic                    r_v1, r_v2, r_v3;
    logic [scg_pkg::U_W-1:0] r_u1, r_u2;
    logic [scg_pkg::Q_W-1:0] r_q2;
    logic [scg_pkg::M_W-1:0] r_m3;

    logic [scg_pkg::U_W-1:0]              n_u1;
    logic [scg_pkg::U_W+scg_pkg::R_W-1:0] n_prod;
    logic [scg_pkg::Q_W-1:0]              n_q2;
    logic [scg_pkg::U_W-1:0]              n_diff;
    logic [scg_pkg::M_W-1:0]              n_m3;

    always_comb begin
        // flipping the sign bit adds 32768
        n_u1   = scg_pkg::U_W'({~i_angle[scg_pkg::ANGLE_W-1], i_angle[scg_pkg::ANGLE_W-2:0]})
                 + scg_pkg::U_W'(scg_pkg::WRAP_OFS);
        n_prod = (scg_pkg::U_W+scg_pkg::R_W)'(r_u1)
                 * (scg_pkg::U_W+scg_pkg::R_W)'(scg_pkg::Q_RECIP);
        n_q2   = scg_pkg::Q_W'(n_prod >> scg_pkg::Q_SH);
        n_diff = r_u2 - scg_pkg::U_W'(scg_pkg::U_W'(r_q2) * scg_pkg::U_W'(scg_pkg::FULL_TURN));
        n_m3   = scg_pkg::M_W'(n_diff);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_u1 <= n_u1;
            r_u2 <= r_u1;
            r_q2 <= n_q2;
            r_m3 <= n_m3;
        end
    end

    assign o_valid = r_v3;
    assign o_m     = r_m3;

endmodule

@@ rtl/core/scg_select.sv @@
`timescale 1ns / 1ps

module scg_select (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [scg_pkg::M_W-1:0]     i_m,
    input  logic [scg_pkg::COLOR_W-1:0] i_day,
    input  logic [scg_pkg::COLOR_W-1:0] i_night,
    input  logic [scg_pkg::COLOR_W-1:0] i_dawn,
    output logic                        o_valid,
    output scg_pkg::t_sel_beat          o_beat
);

    logic               r_v;
    scg_pkg::t_sel_beat r_beat;
    scg_pkg::t_sel_beat n_beat;

    always_comb begin
        n_beat.s_color = i_day;
        n_beat.e_color = i_day;
        n_beat.off     = '0;
        if (i_m >= scg_pkg::M_W'(scg_pkg::DAY_LO) && i_m < scg_pkg::M_W'(scg_pkg::DAY_HI)) begin
            n_beat.s_color = i_day;
            n_beat.e_color = i_day;
        end else if (i_m >= scg_pkg::M_W'(scg_pkg::NIGHT_LO)
                     && i_m < scg_pkg::M_W'(scg_pkg::NIGHT_HI)) begin
            n_beat.s_color = i_night;
            n_beat.e_color = i_night;
        end else if (i_m < scg_pkg::M_W'(scg_pkg::DAY_LO)) begin
            n_beat.s_color = i_dawn;
            n_beat.e_color = i_day;
            n_beat.off     = scg_pkg::OFF_W'(i_m);
        end else if (i_m < scg_pkg::M_W'(scg_pkg::DUSK_MID)) begin
            n_beat.s_color = i_day;
            n_beat.e_color = i_dawn;
            n_beat.off     = scg_pkg::OFF_W'(i_m - scg_pkg::M_W'(scg_pkg::DAY_HI));
        end else if (i_m < scg_pkg::M_W'(scg_pkg::NIGHT_LO)) begin
            n_beat.s_color = i_dawn;
            n_beat.e_color = i_night;
            n_beat.off     = scg_pkg::OFF_W'(i_m - scg_pkg::M_W'(scg_pkg::DUSK_MID));
        end else begin
            n_beat.s_color = i_night;
            n_beat.e_color = i_dawn;
            n_beat.off     = scg_pkg::OFF_W'(i_m - scg_pkg::M_W'(scg_pkg::NIGHT_HI));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_en) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_beat <= n_beat;
        end
    end

    assign o_valid = r_v;
    assign o_beat  = r_beat;

endmodule

@@ rtl/core/scg_blend.sv @@
`timescale 1ns / 1ps

module scg_blend (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  scg_pkg::t_sel_beat       i_beat,
    output logic                     o_valid,
    output logic [scg_pkg::CH_W-1:0] o_red,
    output logic [scg_pkg::CH_W-1:0] o_green,
    output logic [scg_pkg::CH_W-1:0] o_blue,
    output logic [scg_pkg::CH_W-1:0] o_alpha
);

    logic                      r_va, r_vb;
    logic [scg_pkg::NUM_W-1:0] r_num [scg_pkg::N_CH];
    logic [scg_pkg::CH_W-1:0]  r_ch  [scg_pkg::N_CH];

    logic [scg_pkg::CH_W-1:0]                n_sc   [scg_pkg::N_CH];
    logic [scg_pkg::CH_W-1:0]                n_ec   [scg_pkg::N_CH];
    logic signed [scg_pkg::CH_W:0]           n_diff [scg_pkg::N_CH];
    logic signed [scg_pkg::SUM_W-1:0]        n_prod [scg_pkg::N_CH];
    logic [scg_pkg::NUM_W-1:0]               n_base [scg_pkg::N_CH];
    logic signed [scg_pkg::SUM_W-1:0]        n_sum  [scg_pkg::N_CH];
    logic [scg_pkg::NUM_W-1:0]               n_x    [scg_pkg::N_CH];
    logic [scg_pkg::NUM_W+scg_pkg::DR_W-1:0] n_y    [scg_pkg::N_CH];
    logic [scg_pkg::CH_W-1:0]                n_ch   [scg_pkg::N_CH];

    // stage a: start*seg + (end-start)*off, red in the top byte
    always_comb begin
        for (int k = 0; k < scg_pkg::N_CH; k++) begin
            n_sc[k]   = i_beat.s_color[scg_pkg::COLOR_W-1-scg_pkg::CH_W*k -: scg_pkg::CH_W];
            n_ec[k]   = i_beat.e_color[scg_pkg::COLOR_W-1-scg_pkg::CH_W*k -: scg_pkg::CH_W];
            n_diff[k] = $signed({1'b0, n_ec[k]}) - $signed({1'b0, n_sc[k]});
            n_prod[k] = scg_pkg::SUM_W'(n_diff[k]) * $signed(scg_pkg::SUM_W'(i_beat.off));
            n_base[k] = scg_pkg::NUM_W'(n_sc[k]) * scg_pkg::NUM_W'(scg_pkg::SEG_LEN);
            n_sum[k]  = $signed(scg_pkg::SUM_W'(n_base[k])) + n_prod[k];
        end
    end

    // stage b: round to nearest, divide by segment length via reciprocal
    always_comb begin
        for (int k = 0; k < scg_pkg::N_CH; k++) begin
            n_x[k]  = r_num[k] + scg_pkg::NUM_W'(scg_pkg::SEG_LEN / 2);
            n_y[k]  = (scg_pkg::NUM_W+scg_pkg::DR_W)'(n_x[k])
                      * (scg_pkg::NUM_W+scg_pkg::DR_W)'(scg_pkg::D_RECIP);
            n_ch[k] = scg_pkg::CH_W'(n_y[k] >> scg_pkg::D_SH);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else if (i_en) begin
            r_va <= i_valid;
            r_vb <= r_va;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < scg_pkg::N_CH; k++) begin
                r_num[k] <= scg_pkg::NUM_W'(n_sum[k]);
                r_ch[k]  <= n_ch[k];
            end
        end
    end

    assign o_valid = r_vb;
    assign o_red   = r_ch[0];
    assign o_green = r_ch[1];
    assign o_blue  = r_ch[2];
    assign o_alpha = r_ch[3];

endmodule
